### hdl/mta_pkg.sv
// Package of the marker track association core: widths, codes, command and
// result structures, and the slot-vector helper functions.
// Depends on nothing; every other file of the block imports it.
package mta_pkg;

  localparam int MARKERS    = 8;
  localparam int IDX_W      = (MARKERS > 1) ? $clog2(MARKERS) : 1;
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int MOVE_W     = 8;
  localparam int NUM_W      = 6;
  localparam int SLOT_W     = 7;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Depth of both the command queue and the result queue (a power of two).
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OP_W-1:0] OP_POINT  = 3'd0;
  localparam logic [OP_W-1:0] OP_EOF    = 3'd1;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE     = 2'd2;

  localparam logic [DIM_W-1:0]  FRAME_WIDTH_RST  = 13'd320;
  localparam logic [DIM_W-1:0]  FRAME_HEIGHT_RST = 13'd240;
  localparam logic [MOVE_W-1:0] MAX_MOVE_RST     = 8'd8;
  localparam logic [MOVE_W-1:0] MAX_MOVE_MIN     = 8'd3;

  typedef enum logic [1:0] {
    KIND_MOVED    = 2'd0,
    KIND_LOST     = 2'd1,
    KIND_INSERTED = 2'd2,
    KIND_FULL     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CMD_POINT  = 3'd0,
    CMD_EOF    = 3'd1,
    CMD_MARK   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [IDX_W-1:0]    idx;
  } cmd_t;

  typedef struct packed {
    kind_e               kind;
    logic [SLOT_W-1:0]   slot;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                last;
  } res_t;

  // Keeps only the lowest set bit of a slot vector.
  function automatic logic [MARKERS-1:0] lowest_bit(input logic [MARKERS-1:0] vec);
    return vec & (~vec + MARKERS'(1));
  endfunction

  function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [MARKERS-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MARKERS; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### hdl/mta_front.sv
// Front end of the marker track association core: accepts input items,
// classifies them into commands and holds them in a short queue.
// Depends on mta_pkg.
module mta_front import mta_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [OP_W-1:0]     op_i,
  input  logic [COORD_W-1:0]  pos_x_i,
  input  logic [COORD_W-1:0]  pos_y_i,
  input  logic                point_ok_i,
  input  logic [NUM_W-1:0]    marker_number_i,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  cmd_t              cmd_in;
  logic              keep;
  logic              wr_en;
  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  // Items that can have no effect (failed points, deletes out of range,
  // unknown operations) are accepted and dropped here.
  always_comb begin
    cmd_in.x   = pos_x_i;
    cmd_in.y   = pos_y_i;
    cmd_in.idx = IDX_W'(marker_number_i - NUM_W'(1));
    cmd_in.cmd = CMD_POINT;
    keep       = 1'b0;
    unique case (op_i)
      OP_POINT: begin
        cmd_in.cmd = CMD_POINT;
        keep       = point_ok_i;
      end
      OP_EOF: begin
        cmd_in.cmd = CMD_EOF;
        keep       = 1'b1;
      end
      OP_MARK: begin
        cmd_in.cmd = CMD_MARK;
        keep       = 1'b1;
      end
      OP_DELETE: begin
        cmd_in.cmd = CMD_DELETE;
        keep       = (marker_number_i != '0) &&
                     ({1'b0, marker_number_i} <= SLOT_W'(MARKERS));
      end
      OP_CLEAR: begin
        cmd_in.cmd = CMD_CLEAR;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full        = (cnt_q == QCNT_W'(QDEPTH));
  assign wr_en       = push && !full && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    if (wr_en && !cmd_pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!wr_en && cmd_pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= cmd_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("command queue count beyond its depth");

  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cnt_q != '0)
    else $error("command taken from an empty queue");

  a_drop_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !keep && !cmd_pop_i) |=> $stable(cnt_q))
    else $error("dropped item changed the queue count");

endmodule

### hdl/mta_back.sv
// Back end of the marker track association core: configuration registers,
// the marker table and the sequencer that carries out commands and emits results.
// Depends on mta_pkg.
module mta_back import mta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  output logic                  res_push_o,
  output res_t                  res_o,
  input  logic                  res_full_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [DIM_W-1:0]   frame_width_q, frame_height_q;
  logic [MOVE_W-1:0]  max_move_q;

  logic [MARKERS-1:0] valid_q, valid_d;
  logic [MARKERS-1:0] found_q, found_d;
  logic [COORD_W-1:0] slot_x_q [MARKERS];
  logic [COORD_W-1:0] slot_y_q [MARKERS];
  logic [MARKERS-1:0] pos_we;

  logic               state_q, state_d;
  kind_e              em_kind_q, em_kind_d;
  logic [MARKERS-1:0] em_vec_q, em_vec_d;
  logic [COORD_W-1:0] em_x_q, em_x_d;
  logic [COORD_W-1:0] em_y_q, em_y_d;

  logic [MARKERS-1:0] match;
  logic [MARKERS-1:0] free_oh;
  logic               in_frame;
  logic [MARKERS-1:0] pick;
  logic [MARKERS-1:0] rest;
  logic [COORD_W-1:0] dx [MARKERS];
  logic [COORD_W-1:0] dy [MARKERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      max_move_q     <= MAX_MOVE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_MAX_MOVE: begin
          // Distances below the minimum would lose markers at once.
          if (cfg_data_i[MOVE_W-1:0] >= MAX_MOVE_MIN) begin
            max_move_q <= cfg_data_i[MOVE_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Every slot compares only its own position, so checking all slots at once
  // gives the same answer as checking them in slot order.
  always_comb begin
    for (int i = 0; i < MARKERS; i++) begin
      dx[i] = (cmd_i.x >= slot_x_q[i]) ? cmd_i.x - slot_x_q[i] : slot_x_q[i] - cmd_i.x;
      dy[i] = (cmd_i.y >= slot_y_q[i]) ? cmd_i.y - slot_y_q[i] : slot_y_q[i] - cmd_i.y;
      match[i] = valid_q[i] && (dx[i] <= COORD_W'(max_move_q)) &&
                 (dy[i] <= COORD_W'(max_move_q));
    end
  end

  assign free_oh  = lowest_bit(~valid_q);
  assign in_frame = ({1'b0, cmd_i.x} < frame_width_q) && ({1'b0, cmd_i.y} < frame_height_q);

  assign pick = lowest_bit(em_vec_q);
  assign rest = em_vec_q & ~pick;

  always_comb begin
    res_o.kind = em_kind_q;
    res_o.x    = em_x_q;
    res_o.y    = em_y_q;
    if (em_kind_q == KIND_FULL) begin
      res_o.slot = '0;
      res_o.last = 1'b1;
    end else begin
      res_o.slot = SLOT_W'(onehot_to_idx(pick)) + SLOT_W'(1);
      res_o.last = (rest == '0);
    end
  end

  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    found_d    = found_q;
    pos_we     = '0;
    em_kind_d  = em_kind_q;
    em_vec_d   = em_vec_q;
    em_x_d     = em_x_q;
    em_y_d     = em_y_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          em_x_d    = cmd_i.x;
          em_y_d    = cmd_i.y;
          unique case (cmd_i.cmd)
            CMD_POINT: begin
              pos_we    = match;
              found_d   = found_q | match;
              em_kind_d = KIND_MOVED;
              em_vec_d  = match;
              if (match != '0) begin
                state_d = ST_EMIT;
              end
            end
            CMD_EOF: begin
              valid_d   = valid_q & found_q;
              found_d   = '0;
              em_kind_d = KIND_LOST;
              em_vec_d  = valid_q & ~found_q;
              em_x_d    = '0;
              em_y_d    = '0;
              if ((valid_q & ~found_q) != '0) begin
                state_d = ST_EMIT;
              end
            end
            CMD_MARK: begin
              if (in_frame) begin
                state_d = ST_EMIT;
                if (free_oh != '0) begin
                  valid_d   = valid_q | free_oh;
                  pos_we    = free_oh;
                  em_kind_d = KIND_INSERTED;
                  em_vec_d  = free_oh;
                end else begin
                  em_kind_d = KIND_FULL;
                  em_vec_d  = '0;
                end
              end
            end
            CMD_DELETE: begin
              valid_d[cmd_i.idx] = 1'b0;
            end
            CMD_CLEAR: begin
              valid_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_EMIT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          em_vec_d   = rest;
          if (res_o.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      found_q   <= '0;
      em_kind_q <= KIND_MOVED;
      em_vec_q  <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      found_q   <= found_d;
      em_kind_q <= em_kind_d;
      em_vec_q  <= em_vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    em_x_q <= em_x_d;
    em_y_q <= em_y_d;
    for (int i = 0; i < MARKERS; i++) begin
      if (pos_we[i]) begin
        slot_x_q[i] <= cmd_i.x;
        slot_y_q[i] <= cmd_i.y;
      end
    end
  end

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == ST_IDLE) && cmd_valid_i)
    else $error("command taken while results are still pending");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last) |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after the final result");

  a_emit_has_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && em_kind_q != KIND_FULL) |-> em_vec_q != '0)
    else $error("emission with no slot left to report");

endmodule

### hdl/mta_res_fifo.sv
// Result queue of the marker track association core: a short queue of result
// transactions that parts the sequencer from the receiver.
// Depends on mta_pkg.
module mta_res_fifo import mta_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign res_o   = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      q_mem[wr_ptr_q] <= res_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue count beyond its depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result queue overrun");

  a_pop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !push_i) |=> cnt_q == $past(cnt_q) - QCNT_W'(1))
    else $error("result queue count did not drop on a pop");

endmodule

### hdl/marker_track_association_core.sv
// Top level of the marker track association core: front end, back end and
// result queue. Depends on mta_pkg, mta_front, mta_back and mta_res_fifo.
//
// Usage: items enter through a queue-like port (push/full) with fields op_i,
// pos_x_i, pos_y_i, point_ok_i and marker_number_i. Results leave through a
// queue-like port (empty/pop) with kind_o, slot_o, out_x_o, out_y_o and
// last_o; last_o marks the final result of one item. The user must see that
// registers are written through cfg_we_i, cfg_idx_i and cfg_data_i only while
// the block is idle; the block itself does not enforce it. Timing: the front
// end queues a classified item. The back end takes one command per cycle when
// idle, updates the marker table in that cycle and then emits one result per
// cycle while the result queue has room. The first result of an item passes
// through the command queue, the emission registers and the result queue.
// Items that can have no effect are dropped by the front end at once.
// Reset empties both queues, frees every marker and restores the registers
// to width 320, height 240 and max_move 8. When the receiver stalls, the
// result queue fills, the sequencer waits, and then the command queue fills
// and full is raised; nothing is lost.
module marker_track_association_core import mta_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic [OP_W-1:0]       op_i,
  input  logic [COORD_W-1:0]    pos_x_i,
  input  logic [COORD_W-1:0]    pos_y_i,
  input  logic                  point_ok_i,
  input  logic [NUM_W-1:0]      marker_number_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            kind_o,
  output logic [SLOT_W-1:0]     slot_o,
  output logic [COORD_W-1:0]    out_x_o,
  output logic [COORD_W-1:0]    out_y_o,
  output logic                  last_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_out;

  mta_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .op_i            (op_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .point_ok_i      (point_ok_i),
    .marker_number_i (marker_number_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  mta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  mta_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_out)
  );

  assign kind_o  = res_out.kind;
  assign slot_o  = res_out.slot;
  assign out_x_o = res_out.x;
  assign out_y_o = res_out.y;
  assign last_o  = res_out.last;

endmodule
